@@ rtl/cse_pkg.sv @@
package cse_pkg;

    localparam int ID_W      = 29;
    localparam int PAYLOAD_W = 64;
    localparam int DLC_W     = 4;
    localparam int START_W   = 6;
    localparam int LEN_W     = 7;
    localparam int GAIN_W    = 32;
    localparam int VALUE_W   = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [LEN_W-1:0]   MAX_LEN      = 7'd64;
    localparam logic [DLC_W-1:0]   MAX_DLC      = 4'd8;
    localparam logic [LEN_W-1:0]   RESET_LEN    = 7'd8;
    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 32'sd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MESSAGE_ID = 3'd0,
        CFG_START_BIT  = 3'd1,
        CFG_BIT_LENGTH = 3'd2,
        CFG_BYTE_ORDER = 3'd3,
        CFG_IS_SIGNED  = 3'd4,
        CFG_GAIN       = 3'd5,
        CFG_BIAS       = 3'd6
    } cfg_index_t;

    localparam logic BYTE_ORDER_MOTOROLA = 1'b0;
    localparam logic BYTE_ORDER_INTEL    = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]      frame_id;
        logic [PAYLOAD_W-1:0] payload;
        logic [DLC_W-1:0]     data_length;
    } frame_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] raw_value;
        logic signed [VALUE_W-1:0] scaled_value;
        logic                      is_integer;
        logic                      beyond_data;
        logic                      saturated;
    } result_t;

endpackage

@@ rtl/cse_frame_if.sv @@
interface cse_frame_if;
    logic            valid;
    logic            ready;
    cse_pkg::frame_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/cse_result_if.sv @@
interface cse_result_if;
    logic             valid;
    logic             ready;
    cse_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/can_signal_extract.sv @@
// CAN signal decoder for one configured DBC signal.
// frame: valid/ready channel of received frames (identifier, eight data bytes,
//   data length). Frames whose identifier differs from message_id are taken
//   and dropped without a result.
// result: valid/ready channel with the raw and scaled signal and three flags.
// Configuration: write wr_data to register wr_index when wr_en is high; write
//   only while no item is in flight.
// Pipeline: a frame passes one register per stage (input, extract, partial
//   products, sum and clip) before its result is valid.
// Throughput: one frame per cycle while result.ready is high; the
//   partial-product stage holds two 33 x 32 multipliers so the 65 x 32
//   scaling keeps that rate.
// Reset: registers return to identifier 0, start bit 0, eight bits, Intel
//   order, unsigned, gain 1.0, bias 0; the pipeline is empty.
// Stall: while result.ready is low the result holds, the stages behind it
//   fill, and frame.ready drops once every stage holds an item.
module can_signal_extract (
    input  logic                              clk,
    input  logic                              rst_n,
    cse_frame_if.sink                         frame,
    cse_result_if.source                      result,
    input  logic                              wr_en,
    input  logic [cse_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [cse_pkg::CFG_W-1:0]         wr_data
);

    // configuration
    logic [cse_pkg::ID_W-1:0]           message_id_reg;
    logic [cse_pkg::START_W-1:0]        start_bit_reg;
    logic [cse_pkg::LEN_W-1:0]          bit_length_reg;
    logic                               byte_order_reg;
    logic                               is_signed_reg;
    logic signed [cse_pkg::GAIN_W-1:0]  gain_reg;
    logic signed [cse_pkg::GAIN_W-1:0]  bias_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            message_id_reg <= '0;
            start_bit_reg  <= '0;
            bit_length_reg <= cse_pkg::RESET_LEN;
            byte_order_reg <= cse_pkg::BYTE_ORDER_INTEL;
            is_signed_reg  <= 1'b0;
            gain_reg       <= cse_pkg::GAIN_ONE;
            bias_reg       <= '0;
        end
        else if (wr_en)
        begin
            case (cse_pkg::cfg_index_t'(wr_index))
                cse_pkg::CFG_MESSAGE_ID: message_id_reg <= wr_data[cse_pkg::ID_W-1:0];
                cse_pkg::CFG_START_BIT:  start_bit_reg  <= wr_data[cse_pkg::START_W-1:0];
                cse_pkg::CFG_BIT_LENGTH: bit_length_reg <= wr_data[cse_pkg::LEN_W-1:0];
                cse_pkg::CFG_BYTE_ORDER: byte_order_reg <= wr_data[0];
                cse_pkg::CFG_IS_SIGNED:  is_signed_reg  <= wr_data[0];
                cse_pkg::CFG_GAIN:       gain_reg       <= wr_data;
                cse_pkg::CFG_BIAS:       bias_reg       <= wr_data;
                default: ;
            endcase
        end
    end

    // stage handshake: a stage loads when it is empty or the next one loads
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_en, s2_en, s3_en, s4_en;

    assign s4_en       = !s4_valid_reg || result.ready;
    assign s3_en       = !s3_valid_reg || s4_en;
    assign s2_en       = !s2_valid_reg || s3_en;
    assign s1_en       = !s1_valid_reg || s2_en;
    assign frame.ready = s1_en;

    logic s1_valid_next;
    assign s1_valid_next = frame.valid && (frame.data.frame_id == message_id_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= s1_valid_next;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (s3_en)
                s3_valid_reg <= s2_valid_reg;
            if (s4_en)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: input register
    logic [cse_pkg::PAYLOAD_W-1:0] s1_payload_reg;
    logic [cse_pkg::DLC_W-1:0]     s1_dlc_reg;

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_payload_reg <= frame.data.payload;
            s1_dlc_reg     <= frame.data.data_length;
        end
    end

    // stage 2: extract the signal
    // Motorola bits are walked in a linear order where each byte is read
    // from bit 7 down to bit 0; reversing every byte makes that walk a
    // plain right shift, and the field is then bit-reversed into raw.
    logic [cse_pkg::LEN_W-1:0]     len;
    logic [cse_pkg::START_W-1:0]   first_pos;
    logic [cse_pkg::PAYLOAD_W-1:0] swapped;
    logic [cse_pkg::PAYLOAD_W-1:0] src;
    logic [cse_pkg::PAYLOAD_W-1:0] field;
    logic [cse_pkg::PAYLOAD_W-1:0] field_rev;
    logic [cse_pkg::PAYLOAD_W-1:0] len_mask;
    logic [cse_pkg::PAYLOAD_W-1:0] bits;
    logic [cse_pkg::LEN_W-1:0]     rev_shift;
    logic [cse_pkg::DLC_W-1:0]     dlc;
    logic [cse_pkg::LEN_W:0]       last_pos;
    logic [cse_pkg::LEN_W:0]       limit;
    logic [cse_pkg::START_W-1:0]   msb_idx;
    logic                          s2_neg_next;
    logic                          s2_beyond_next;
    logic [cse_pkg::VALUE_W-1:0]   s2_raw_next;

    always_comb
    begin
        len       = (bit_length_reg > cse_pkg::MAX_LEN) ? cse_pkg::MAX_LEN : bit_length_reg;
        first_pos = (byte_order_reg == cse_pkg::BYTE_ORDER_INTEL) ? start_bit_reg
                  : {start_bit_reg[5:3], ~start_bit_reg[2:0]};
        for (int k = 0; k < cse_pkg::PAYLOAD_W; k++)
            swapped[k] = s1_payload_reg[(k & ~7) + (7 - (k & 7))];
        src   = (byte_order_reg == cse_pkg::BYTE_ORDER_INTEL) ? s1_payload_reg : swapped;
        field = src >> first_pos;
        for (int k = 0; k < cse_pkg::PAYLOAD_W; k++)
            field_rev[k] = field[cse_pkg::PAYLOAD_W-1-k];
        len_mask  = ~({cse_pkg::PAYLOAD_W{1'b1}} << len);
        rev_shift = cse_pkg::MAX_LEN - len;
        bits = (byte_order_reg == cse_pkg::BYTE_ORDER_INTEL) ? (field & len_mask)
             : (field_rev >> rev_shift);

        dlc      = (s1_dlc_reg > cse_pkg::MAX_DLC) ? cse_pkg::MAX_DLC : s1_dlc_reg;
        limit    = {1'b0, dlc, 3'b000};
        last_pos = {2'b00, first_pos} + {1'b0, len} - 8'd1;
        s2_beyond_next = (len != '0) && (last_pos >= limit);

        msb_idx     = len[cse_pkg::START_W-1:0] - 6'd1;
        s2_neg_next = is_signed_reg && (len != '0) && bits[msb_idx];
        s2_raw_next = s2_neg_next ? (bits | ~len_mask) : bits;
    end

    logic [cse_pkg::VALUE_W-1:0] s2_raw_reg;
    logic                        s2_neg_reg;
    logic                        s2_beyond_reg;

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            s2_raw_reg    <= s2_raw_next;
            s2_neg_reg    <= s2_neg_next;
            s2_beyond_reg <= s2_beyond_next;
        end
    end

    // stage 3: two partial products of the 65-bit raw value and the gain
    logic signed [32:0] mul_lo_op;
    logic signed [32:0] mul_hi_op;
    logic signed [64:0] s3_plo_next;
    logic signed [64:0] s3_phi_next;

    assign mul_lo_op   = {1'b0, s2_raw_reg[31:0]};
    assign mul_hi_op   = {s2_neg_reg, s2_raw_reg[63:32]};
    assign s3_plo_next = mul_lo_op * gain_reg;
    assign s3_phi_next = mul_hi_op * gain_reg;

    logic signed [64:0]          s3_plo_reg;
    logic signed [64:0]          s3_phi_reg;
    logic [cse_pkg::VALUE_W-1:0] s3_raw_reg;
    logic                        s3_beyond_reg;

    always_ff @(posedge clk)
    begin
        if (s3_en)
        begin
            s3_plo_reg    <= s3_plo_next;
            s3_phi_reg    <= s3_phi_next;
            s3_raw_reg    <= s2_raw_reg;
            s3_beyond_reg <= s2_beyond_reg;
        end
    end

    // stage 4: sum, add bias, clip to 64 bits
    logic [97:0]      sum;
    logic             fits;
    cse_pkg::result_t s4_next;

    always_comb
    begin
        sum  = {{33{s3_plo_reg[64]}}, s3_plo_reg}
             + {s3_phi_reg[64], s3_phi_reg, 32'd0}
             + {{66{bias_reg[31]}}, bias_reg};
        fits = (&sum[97:63]) || !(|sum[97:63]);

        s4_next.raw_value = s3_raw_reg;
        if (fits)
            s4_next.scaled_value = sum[63:0];
        else if (sum[97])
            s4_next.scaled_value = {1'b1, {63{1'b0}}};
        else
            s4_next.scaled_value = {1'b0, {63{1'b1}}};
        s4_next.is_integer  = (gain_reg == cse_pkg::GAIN_ONE) && (bias_reg == '0);
        s4_next.beyond_data = s3_beyond_reg;
        s4_next.saturated   = !fits;
    end

    cse_pkg::result_t s4_reg;

    always_ff @(posedge clk)
    begin
        if (s4_en)
            s4_reg <= s4_next;
    end

    assign result.valid = s4_valid_reg;
    assign result.data  = s4_reg;

endmodule
